// ===== design/dbn_pkg.sv =====
// shared types, codes and defaults for the multichannel input debouncer
`default_nettype none
package dbn_pkg;

  localparam int CHANNELS_DEF   = 8;
  localparam int TICK_WIDTH_DEF = 32;

  localparam int MASK_W   = 8;
  localparam int SETTLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [MASK_W-1:0]   INVERT_MASK_RST  = 8'hFF;
  localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 16'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INVERT_MASK  = 1'b0,
    CFG_SETTLE_TICKS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    HOLD_NONE     = 2'd0,
    HOLD_PRESSED  = 2'd1,
    HOLD_RELEASED = 2'd2
  } hold_t;

  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_PRESS   = 2'd1,
    EDGE_RELEASE = 2'd2
  } edge_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic        raw_level;
    logic [31:0] now_tick;
  } in_word_t;

  typedef struct packed {
    logic [1:0] hold_status;
    logic [1:0] edge_event;
  } out_word_t;

endpackage
`default_nettype wire

// ===== design/dbn_core.sv =====
// per-channel debounce state and its read-modify-write update
`default_nettype none
module dbn_core
  import dbn_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                upd_en,
  input  wire in_word_t            item,
  input  wire logic [MASK_W-1:0]   invert_mask,
  input  wire logic [SETTLE_W-1:0] settle_ticks,
  output out_word_t                result
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W = (TICK_WIDTH > SETTLE_W) ? TICK_WIDTH : SETTLE_W;

  logic                  prev_active_r [CHANNELS];
  logic                  settled_r     [CHANNELS];
  logic [TICK_WIDTH-1:0] change_tick_r [CHANNELS];
  hold_t                 held_state_r  [CHANNELS];
  edge_t                 last_edge_r   [CHANNELS];

  logic [IDX_W-1:0]      idx;
  logic                  ch_ok;
  logic                  active;
  logic [TICK_WIDTH-1:0] now_t;
  logic [TICK_WIDTH-1:0] elapsed;
  logic                  changed;
  logic                  settle_now;
  edge_t                 new_edge;
  hold_t                 new_hold;
  logic                  emit;

  always_comb begin
    idx        = IDX_W'(item.channel);
    ch_ok      = (int'(item.channel) < CHANNELS);
    active     = item.raw_level ^ invert_mask[item.channel];
    now_t      = TICK_WIDTH'(item.now_tick);
    changed    = (active != prev_active_r[idx]);
    elapsed    = now_t - change_tick_r[idx];
    // a fresh change blocks settling and restarts elapsed time from zero at its tick
    settle_now = ch_ok && !changed && !settled_r[idx] &&
                 (CMP_W'(elapsed) > CMP_W'(settle_ticks));
    new_edge   = active ? EDGE_PRESS : EDGE_RELEASE;
    new_hold   = active ? HOLD_PRESSED : HOLD_RELEASED;
    emit       = settle_now && (last_edge_r[idx] != new_edge);

    if (!ch_ok) begin
      result.hold_status = HOLD_NONE;
    end else if (settle_now) begin
      result.hold_status = new_hold;
    end else begin
      result.hold_status = held_state_r[idx];
    end
    result.edge_event = emit ? new_edge : EDGE_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_active_r[i] <= 1'b0;
        settled_r[i]     <= 1'b0;
        change_tick_r[i] <= '0;
        held_state_r[i]  <= HOLD_NONE;
        last_edge_r[i]   <= EDGE_NONE;
      end
    end else if (upd_en && ch_ok) begin
      prev_active_r[idx] <= active;
      if (changed) begin
        change_tick_r[idx] <= now_t;
        settled_r[idx]     <= 1'b0;
      end else if (settle_now) begin
        settled_r[idx]    <= 1'b1;
        held_state_r[idx] <= new_hold;
        if (emit) begin
          last_edge_r[idx] <= new_edge;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/multichannel_input_debouncer.sv =====
// top level of the multichannel input debouncer: handshakes, config registers, result register
//
// usage
//   each input word is one poll of one channel: channel number, raw pin level and the
//   free running tick count at the time of the poll
//   each poll yields exactly one output word: the channel's held status (none, pressed,
//   released) and an edge event (none, press, release) when the channel has just settled
//   to a level different from the last edge reported on it
//   cfg port writes invert_mask (index 0) and settle_ticks (index 1); the user must write
//   them only while idle, the block itself does not enforce it
// timing
//   an accepted word is held in the input register, then passes through the channel state
//   read-modify-write into the result register, which drives out_valid
//   throughput is one word per cycle while out_stall is low; polls of the same channel may
//   follow back to back since the state update lands at the same edge the result is captured
// reset
//   synchronous active low: all channel state cleared, invert_mask = 0xff,
//   settle_ticks = 30, both pipeline stages empty
// stall
//   a stalled output word holds; the input register keeps accepting while the output
//   register is free or being drained, and in_stall rises only when both are full
`default_nettype none
module multichannel_input_debouncer
  import dbn_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // poll words
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_word,
  // result words
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_word,
  // register writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [MASK_W-1:0]   invert_mask_r;
  logic [SETTLE_W-1:0] settle_ticks_r;

  // input stage
  logic     s1_valid_r, s1_valid_nxt;
  in_word_t s1_word_r;

  // output stage
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  out_word_t core_result;

  logic advance;
  logic s1_load;

  // output register frees up when empty or being taken this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign s1_load  = in_valid && !in_stall;

  always_comb begin
    // an empty input register still fills while the output is held
    s1_valid_nxt  = s1_valid_r || s1_load;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = s1_load;
    end
  end

  // register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_mask_r  <= INVERT_MASK_RST;
      settle_ticks_r <= SETTLE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_INVERT_MASK:  invert_mask_r  <= cfg_wdata[MASK_W-1:0];
        CFG_SETTLE_TICKS: settle_ticks_r <= cfg_wdata[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_word;
    end
    if (advance && s1_valid_r) begin
      out_word_r <= core_result;
    end
  end

  // channel state updates exactly when the word moves into the output register
  dbn_core #(
    .CHANNELS   (CHANNELS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd_en       (advance && s1_valid_r),
    .item         (s1_word_r),
    .invert_mask  (invert_mask_r),
    .settle_ticks (settle_ticks_r),
    .result       (core_result)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire
